// ===== design/rgbh_pkg.sv =====
// Shared types, codes and constants for the normalized RGB histogram core.
package rgbh_pkg;

  // Histogram geometry
  localparam int NUM_BINS  = 256;
  localparam int BIN_W     = 8;
  localparam int NUM_LANES = 3;

  // Lane order inside merged vectors
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  // Output fraction field
  localparam int               FRAC_OUT_W = 17;
  localparam logic [FRAC_OUT_W-1:0] FRAC_MAX = {FRAC_OUT_W{1'b1}};

  // Parameter defaults
  localparam int MAX_PIXELS_DEF    = 4194304;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int CNT_W_DEF         = $clog2(MAX_PIXELS_DEF + 1);

  // Action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ACCUM = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Input beat
  typedef struct packed {
    logic [1:0]       action;
    logic [BIN_W-1:0] red_level;
    logic [BIN_W-1:0] green_level;
    logic [BIN_W-1:0] blue_level;
    logic [BIN_W-1:0] bin_select;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [BIN_W-1:0]      bin_number;
    logic [FRAC_OUT_W-1:0] red_fraction;
    logic [FRAC_OUT_W-1:0] green_fraction;
    logic [FRAC_OUT_W-1:0] blue_fraction;
  } out_item_t;

  // Command from the front end to each lane
  typedef struct packed {
    logic clear;
    logic acc_en;
    logic rd_en;
  } lane_cmd_t;

  // Status from a lane to the merge stage
  typedef struct packed {
    logic                  done;
    logic [FRAC_OUT_W-1:0] quo;
  } lane_res_t;

endpackage

// ===== design/rgbh_div.sv =====
// Bit-serial restoring divider: floor(num * 2^FRAC_BITS / den), saturated.
module rgbh_div import rgbh_pkg::*; #(
  parameter int CNT_W     = CNT_W_DEF,
  parameter int FRAC_BITS = FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] num,
  input  logic [CNT_W-1:0] den,
  input  logic             take,
  output lane_res_t        res
);

  localparam int Q_W    = FRAC_BITS + 1;
  localparam int STEP_W = $clog2(FRAC_BITS + 2);
  localparam int EXT_W  = (Q_W > FRAC_OUT_W) ? Q_W : FRAC_OUT_W;

  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]  den_r;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, first_r, done_r;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic [EXT_W-1:0]  q_ext;

  // One quotient bit per cycle; the first step compares without a shift
  always_comb begin
    trial   = first_r ? rem_r : {rem_r[CNT_W-1:0], 1'b0};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
    q_nxt   = {q_r[Q_W-2:0], ge};
  end

  // Control: step counter, busy and done flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      first_r <= 1'b0;
      step_r  <= '0;
    end else if (start) begin
      busy_r  <= 1'b1;
      done_r  <= 1'b0;
      first_r <= 1'b1;
      step_r  <= STEP_W'(Q_W);
    end else if (busy_r) begin
      first_r <= 1'b0;
      step_r  <= step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else if (take) begin
      done_r <= 1'b0;
    end
  end

  // Datapath: remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  // Empty histogram gives zero; clamp anything past the field width
  always_comb begin
    q_ext    = EXT_W'(q_r);
    res.done = done_r;
    if (den_r == '0) begin
      res.quo = '0;
    end else if (q_ext > EXT_W'(FRAC_MAX)) begin
      res.quo = FRAC_MAX;
    end else begin
      res.quo = q_ext[FRAC_OUT_W-1:0];
    end
  end

endmodule

// ===== design/rgbh_lane.sv =====
// One color lane: 256-bin count memory with increment pipeline and divider.
module rgbh_lane import rgbh_pkg::*; #(
  parameter int CNT_W     = CNT_W_DEF,
  parameter int FRAC_BITS = FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lane_cmd_t        cmd,
  input  logic [BIN_W-1:0] addr,
  input  logic [CNT_W-1:0] total,
  input  logic             take,
  output lane_res_t        res
);

  logic [CNT_W-1:0] bin_mem [NUM_BINS];
  logic [CNT_W-1:0] rd_q_r;
  logic [NUM_BINS-1:0] vld_r;

  logic             s1_acc_r, s1_rd_r;
  logic [BIN_W-1:0] s1_addr_r;
  logic             last_wr_r;
  logic [BIN_W-1:0] last_addr_r;
  logic [CNT_W-1:0] last_data_r;
  logic [CNT_W-1:0] cur_cnt, inc_cnt;

  // Current count: bypass last cycle's write, unwritten bins read as zero
  always_comb begin
    if (last_wr_r && (last_addr_r == s1_addr_r)) begin
      cur_cnt = last_data_r;
    end else if (vld_r[s1_addr_r]) begin
      cur_cnt = rd_q_r;
    end else begin
      cur_cnt = '0;
    end
    inc_cnt = cur_cnt + 1'b1;
  end

  // Count memory: registered read at accept, write back on the following cycle
  always_ff @(posedge clk) begin
    if (cmd.acc_en || cmd.rd_en) begin
      rd_q_r <= bin_mem[addr];
    end
    if (s1_acc_r) begin
      bin_mem[s1_addr_r] <= inc_cnt;
    end
  end

  // Per-bin valid bits; clear drops them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.clear) begin
      vld_r <= '0;
    end else if (s1_acc_r) begin
      vld_r[s1_addr_r] <= 1'b1;
    end
  end

  // Stage 1 control and write bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_acc_r  <= 1'b0;
      s1_rd_r   <= 1'b0;
      last_wr_r <= 1'b0;
    end else begin
      s1_acc_r  <= cmd.acc_en;
      s1_rd_r   <= cmd.rd_en;
      last_wr_r <= s1_acc_r && !cmd.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en || cmd.rd_en) begin
      s1_addr_r <= addr;
    end
    if (s1_acc_r) begin
      last_addr_r <= s1_addr_r;
      last_data_r <= inc_cnt;
    end
  end

  // Normalize the bin count against the pixel total
  rgbh_div #(
    .CNT_W     (CNT_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (s1_rd_r),
    .num   (cur_cnt),
    .den   (total),
    .take  (take),
    .res   (res)
  );

endmodule

// ===== design/rgbh_merge.sv =====
// Merge stage: gathers the three lane fractions into the output register.
module rgbh_merge import rgbh_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lane_res_t [NUM_LANES-1:0]   lane_res,
  input  logic [BIN_W-1:0]            bin_number,
  input  logic                        out_stall,
  output logic                        take,
  output logic                        out_valid,
  output out_item_t                   out_data
);

  logic      all_done;
  logic      out_valid_r;
  out_item_t out_data_r;

  // Load when every lane has finished and the output slot frees up
  always_comb begin
    all_done = lane_res[LANE_RED].done && lane_res[LANE_GREEN].done &&
               lane_res[LANE_BLUE].done;
    take     = all_done && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.bin_number     <= bin_number;
      out_data_r.red_fraction   <= lane_res[LANE_RED].quo;
      out_data_r.green_fraction <= lane_res[LANE_GREEN].quo;
      out_data_r.blue_fraction  <= lane_res[LANE_BLUE].quo;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/rgb_histogram_normalized_core.sv =====
// Normalized RGB histogram: three count lanes, a pixel total and a result merge.
// Clear and accumulate beats are taken one per cycle and produce no result.
// A read beat stalls the input until its result is registered; the wait is set by
// the bit-serial divider in each lane and by any output stall.
// Reset (synchronous, active low) empties every bin and the pixel total.
module rgb_histogram_normalized_core import rgbh_pkg::*; #(
  parameter int MAX_PIXELS    = MAX_PIXELS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);

  logic             accept, is_clr, is_acc, is_rd, take;
  logic [CNT_W-1:0] total_r, rd_total_r;
  logic [BIN_W-1:0] bin_r;
  logic             rd_busy_r;
  lane_cmd_t        cmd;
  logic [NUM_LANES-1:0][BIN_W-1:0] lane_addr;
  lane_res_t [NUM_LANES-1:0]       lane_res;

  // Decode the accepted beat; a full total drops accumulates
  always_comb begin
    accept = in_valid && !in_stall;
    is_clr = accept && (in_data.action == ACT_CLEAR);
    is_acc = accept && (in_data.action == ACT_ACCUM) &&
             (total_r < CNT_W'(MAX_PIXELS));
    is_rd  = accept && (in_data.action == ACT_READ);
    cmd.clear  = is_clr;
    cmd.acc_en = is_acc;
    cmd.rd_en  = is_rd;
  end

  // Bin address per lane: pixel level, or the selected bin for a read
  always_comb begin
    if (in_data.action == ACT_READ) begin
      lane_addr[LANE_RED]   = in_data.bin_select;
      lane_addr[LANE_GREEN] = in_data.bin_select;
      lane_addr[LANE_BLUE]  = in_data.bin_select;
    end else begin
      lane_addr[LANE_RED]   = in_data.red_level;
      lane_addr[LANE_GREEN] = in_data.green_level;
      lane_addr[LANE_BLUE]  = in_data.blue_level;
    end
  end

  // Hold the input while a read is in flight
  assign in_stall = rd_busy_r;

  // Pixel total and read tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      rd_busy_r <= 1'b0;
    end else begin
      if (is_clr) begin
        total_r <= '0;
      end else if (is_acc) begin
        total_r <= total_r + 1'b1;
      end
      if (is_rd) begin
        rd_busy_r <= 1'b1;
      end else if (take) begin
        rd_busy_r <= 1'b0;
      end
    end
  end

  // Capture the read's bin and divisor
  always_ff @(posedge clk) begin
    if (is_rd) begin
      rd_total_r <= total_r;
      bin_r      <= in_data.bin_select;
    end
  end

  // Color lanes side by side
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rgbh_lane #(
      .CNT_W     (CNT_W),
      .FRAC_BITS (FRACTION_BITS)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .addr  (lane_addr[i]),
      .total (rd_total_r),
      .take  (take),
      .res   (lane_res[i])
    );
  end

  // Combine lane fractions into the result beat
  rgbh_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_res   (lane_res),
    .bin_number (bin_r),
    .out_stall  (out_stall),
    .take       (take),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

// ===== tb/rgb_histogram_normalized_core_test.sv =====
// Self-checking testbench for the normalized RGB histogram core.
`timescale 1ns / 1ps

module rgb_histogram_normalized_core_test;
  import rgbh_pkg::*;

  // Action code the core must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int READ_LATENCY = FRACTION_BITS_DEF + 3;
  localparam int RANDOM_BEATS = 800;

  typedef struct {
    in_item_t beat;
    bit       drain_first;
  } stim_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Pending stimulus and expected read results
  stim_t     pending_beats[$];
  out_item_t expected_reads[$];
  stim_t     head;

  // Shadow histogram
  logic [CNT_W_DEF-1:0] red_count   [NUM_BINS];
  logic [CNT_W_DEF-1:0] green_count [NUM_BINS];
  logic [CNT_W_DEF-1:0] blue_count  [NUM_BINS];
  logic [CNT_W_DEF-1:0] pixel_count;

  bit beat_taken;
  int beats_taken;
  int reads_checked;
  int pixels_seen;
  int clears_seen;
  int ignored_seen;
  int error_count;
  int hold_left;
  bit hold_done;

  rgb_histogram_normalized_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Idle-free window for both sides
  function automatic bit quiet_window();
    return beats_taken >= 350 && beats_taken < 500;
  endfunction

  // Floor of count * 2^FRACTION_BITS / total, zero when empty, clipped to 17 bits
  function automatic logic [FRAC_OUT_W-1:0] bin_fraction(logic [CNT_W_DEF-1:0] count,
                                                         logic [CNT_W_DEF-1:0] total);
    logic [63:0] q;
    if (total == '0) return '0;
    q = (64'(count) << FRACTION_BITS_DEF) / 64'(total);
    if (q > 64'(FRAC_MAX)) return FRAC_MAX;
    return q[FRAC_OUT_W-1:0];
  endfunction

  // Update the shadow histogram and queue the expected read result
  task automatic apply_beat(in_item_t b);
    out_item_t want;
    case (b.action)
      ACT_CLEAR: begin
        for (int i = 0; i < NUM_BINS; i++) begin
          red_count[i]   = '0;
          green_count[i] = '0;
          blue_count[i]  = '0;
        end
        pixel_count = '0;
        clears_seen++;
      end
      ACT_ACCUM: begin
        if (pixel_count < MAX_PIXELS_DEF) begin
          red_count[b.red_level]     = red_count[b.red_level] + 1'b1;
          green_count[b.green_level] = green_count[b.green_level] + 1'b1;
          blue_count[b.blue_level]   = blue_count[b.blue_level] + 1'b1;
          pixel_count                = pixel_count + 1'b1;
        end
        pixels_seen++;
      end
      ACT_READ: begin
        want.bin_number     = b.bin_select;
        want.red_fraction   = bin_fraction(red_count[b.bin_select], pixel_count);
        want.green_fraction = bin_fraction(green_count[b.bin_select], pixel_count);
        want.blue_fraction  = bin_fraction(blue_count[b.bin_select], pixel_count);
        expected_reads.push_back(want);
      end
      default: ignored_seen++;
    endcase
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  function automatic void queue_beat(logic [1:0] action, logic [7:0] r, logic [7:0] g,
                                     logic [7:0] b, logic [7:0] sel, bit drain);
    stim_t s;
    s.beat.action      = action;
    s.beat.red_level   = r;
    s.beat.green_level = g;
    s.beat.blue_level  = b;
    s.beat.bin_select  = sel;
    s.drain_first      = drain;
    pending_beats.push_back(s);
  endfunction

  // Pick a level: often a coarse palette so bins fill up, else anything
  function automatic logic [7:0] pick_level();
    if ($urandom_range(1)) return {3'($urandom_range(7)), 5'd0};
    return 8'($urandom_range(255));
  endfunction

  // Monitor: check result beats, then record accepted input beats
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      beat_taken = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          $error("result beat for bin %0d with no read outstanding", out_data.bin_number);
          error_count++;
        end else begin
          want = expected_reads.pop_front();
          check_field("bin_number", want.bin_number, out_data.bin_number);
          check_field("red_fraction", want.red_fraction, out_data.red_fraction);
          check_field("green_fraction", want.green_fraction, out_data.green_fraction);
          check_field("blue_fraction", want.blue_fraction, out_data.blue_fraction);
          reads_checked++;
        end
      end
      beat_taken = in_valid && !in_stall;
      if (beat_taken) begin
        apply_beat(in_data);
        beats_taken++;
      end
    end
  end

  // Driver: hold a beat until taken, then idle, drain or advance
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (pending_beats.size() == 0 || (!quiet_window() && $urandom_range(99) < 9) ||
          (pending_beats[0].drain_first && expected_reads.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        head = pending_beats.pop_front();
        in_data  <= head.beat;
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver: random stalls, one long hold-off while reads keep coming
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && reads_checked == 30) begin
      hold_done = 1'b1;
      hold_left = 200;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_window() && $urandom_range(99) < 9;
    end
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int counted;
    int pick;
    clk      = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    out_stall = 1'b0;
    for (int i = 0; i < NUM_BINS; i++) begin
      red_count[i]   = '0;
      green_count[i] = '0;
      blue_count[i]  = '0;
    end
    pixel_count = '0;

    // Directed: empty reads, extremes, full-scale fraction, ignored code, clear
    queue_beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    queue_beat(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_beat(ACT_ACCUM, 8'd0, 8'd0, 8'd0, 8'hFF, 1'b0);
    queue_beat(ACT_READ, 8'hFF, 8'hFF, 8'hFF, 8'd0, 1'b0);
    queue_beat(ACT_ACCUM, 8'hFF, 8'hFF, 8'hFF, 8'd0, 1'b0);
    queue_beat(ACT_ACCUM, 8'hFF, 8'd0, 8'd128, 8'd0, 1'b0);
    queue_beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'hFF, 1'b0);
    queue_beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    queue_beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd128, 1'b0);
    queue_beat(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'd0, 1'b0);
    queue_beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'hFF, 1'b0);
    queue_beat(ACT_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'hFF, 1'b0);
    queue_beat(ACT_ACCUM, 8'hAA, 8'h55, 8'h0F, 8'd0, 1'b0);
    queue_beat(ACT_ACCUM, 8'h55, 8'hAA, 8'hF0, 8'd0, 1'b0);
    queue_beat(ACT_ACCUM, 8'hAA, 8'hAA, 8'h0F, 8'd0, 1'b0);
    queue_beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'hAA, 1'b0);
    queue_beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'h55, 1'b0);
    queue_beat(ACT_READ, 8'd0, 8'd0, 8'd0, 8'h0F, 1'b0);
    queue_beat(ACT_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);

    // Random: mostly pixels, a quarter reads, rare clears and ignored codes
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      pick = $urandom_range(99);
      if (pick < 1) begin
        queue_beat(ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   counted == 600);
        counted++;
      end else if (pick < 4) begin
        queue_beat(ACT_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   1'b0);
      end else if (pick < 28) begin
        queue_beat(ACT_READ, 8'($urandom), 8'($urandom), 8'($urandom), pick_level(),
                   counted == 600);
        counted++;
      end else begin
        queue_beat(ACT_ACCUM, pick_level(), pick_level(), pick_level(), 8'($urandom),
                   counted == 600);
        counted++;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Drain stimulus, then outstanding reads, then let the pipeline settle
    while (pending_beats.size() != 0 || in_valid) @(posedge clk);
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (READ_LATENCY + 10) @(posedge clk);

    $display("Run covered %0d pixel beats, %0d clears, %0d ignored beats,",
             pixels_seen, clears_seen, ignored_seen);
    $display("and %0d normalized bin reads compared field by field.", reads_checked);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
